### hw/rtl/mipcf_pkg.sv
// Shared types, constants and helpers for the minimum-image pair cutoff filter.
// No dependencies; every module of the block imports this package.
package mipcf_pkg;

   localparam int INDEX_BITS_DEFAULT = 20;
   localparam int COORD_BITS_DEFAULT = 32;

   localparam int CSR_DATA_BITS  = 63;
   localparam int CSR_INDEX_BITS = 3;
   localparam int FIELD_BITS     = 21;
   localparam int MASK_BITS      = 3;
   localparam int CUTOFF_BITS    = 48;
   localparam int SHIFT_BITS     = 8;
   localparam int AXES           = 3;

   localparam int FRAC_POINT   = 35;
   localparam int CELL_POINT   = 8;
   localparam int CUTOFF_POINT = 16;
   localparam int TERM_BITS    = SHIFT_BITS + FIELD_BITS + 2;
   localparam int MAG_BITS     = 32;
   localparam int SQ_BITS      = 2 * MAG_BITS;
   localparam int SUM_BITS     = SQ_BITS + 2;

   localparam logic [MASK_BITS-1:0] MASK_RESET = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CELL_DIAGONAL    = 3'd0,
      CSR_CELL_TILTS       = 3'd1,
      CSR_INVERSE_DIAGONAL = 3'd2,
      CSR_INVERSE_LOWER    = 3'd3,
      CSR_PERIODIC_MASK    = 3'd4,
      CSR_CUTOFF_SQUARED   = 3'd5
   } csr_index_type;

   function automatic logic signed [FIELD_BITS-1:0] cell_field(
      input logic [CSR_DATA_BITS-1:0] packed_value,
      input int unsigned              slot
   );
      return packed_value[slot*FIELD_BITS +: FIELD_BITS];
   endfunction

endpackage

### hw/rtl/mipcf_shift.sv
// Three-stage image shift unit: fractional coordinates through the inverse cell,
// rounding and saturation. Depends on mipcf_pkg.
module mipcf_shift
   import mipcf_pkg::*;
#(
   parameter int DISP_BITS = COORD_BITS_DEFAULT + 1,
   parameter int SIDE_BITS = 2 * INDEX_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [CSR_DATA_BITS-1:0]     inverse_diagonal,
   input  logic [CSR_DATA_BITS-1:0]     inverse_lower,
   input  logic [MASK_BITS-1:0]         periodic_mask,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [DISP_BITS-1:0]  in_disp_x,
   input  logic signed [DISP_BITS-1:0]  in_disp_y,
   input  logic signed [DISP_BITS-1:0]  in_disp_z,
   input  logic [SIDE_BITS-1:0]         in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [DISP_BITS-1:0]  out_disp_x,
   output logic signed [DISP_BITS-1:0]  out_disp_y,
   output logic signed [DISP_BITS-1:0]  out_disp_z,
   output logic [SIDE_BITS-1:0]         out_side,
   output logic signed [SHIFT_BITS-1:0] out_shift_x,
   output logic signed [SHIFT_BITS-1:0] out_shift_y,
   output logic signed [SHIFT_BITS-1:0] out_shift_z
);

   localparam int PROD_BITS = DISP_BITS + FIELD_BITS;
   localparam int FRAC_BITS = PROD_BITS + 2;
   localparam int QUOT_BITS = FRAC_BITS - FRAC_POINT;
   localparam int CALC_BITS = (QUOT_BITS > SHIFT_BITS) ? QUOT_BITS + 1 : SHIFT_BITS + 1;
   localparam logic signed [FRAC_BITS-1:0] ROUND_HALF = FRAC_BITS'(1) << (FRAC_POINT - 1);
   localparam logic signed [CALC_BITS-1:0] SHIFT_MAX = CALC_BITS'(2**(SHIFT_BITS-1) - 1);
   localparam logic signed [CALC_BITS-1:0] SHIFT_MIN = CALC_BITS'(-(2**(SHIFT_BITS-1)));
   localparam int PRODUCTS = 6;

   logic valid_a_ff, valid_b_ff, valid_c_ff;
   logic ready_a, ready_b, ready_c;

   logic signed [DISP_BITS-1:0]  disp_in    [AXES];
   logic signed [DISP_BITS-1:0]  disp_a_ff  [AXES];
   logic signed [DISP_BITS-1:0]  disp_b_ff  [AXES];
   logic signed [DISP_BITS-1:0]  disp_c_ff  [AXES];
   logic [SIDE_BITS-1:0]         side_a_ff, side_b_ff, side_c_ff;
   logic signed [PROD_BITS-1:0]  prod_in    [PRODUCTS];
   logic signed [PROD_BITS-1:0]  prod_ff    [PRODUCTS];
   logic signed [FRAC_BITS-1:0]  frac_in    [AXES];
   logic signed [FRAC_BITS-1:0]  frac_ff    [AXES];
   logic [FRAC_BITS-1:0]         rounded    [AXES];
   logic signed [CALC_BITS-1:0]  quot_ext   [AXES];
   logic signed [CALC_BITS-1:0]  neg_quot   [AXES];
   logic signed [SHIFT_BITS-1:0] shift_in   [AXES];

   assign ready_c  = !valid_c_ff || out_ready;
   assign ready_b  = !valid_b_ff || ready_c;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   assign disp_in[0] = in_disp_x;
   assign disp_in[1] = in_disp_y;
   assign disp_in[2] = in_disp_z;

   always_comb begin
      prod_in[0] = disp_a_ff[0] * cell_field(inverse_diagonal, 0);
      prod_in[1] = disp_a_ff[1] * cell_field(inverse_lower, 0);
      prod_in[2] = disp_a_ff[2] * cell_field(inverse_lower, 1);
      prod_in[3] = disp_a_ff[1] * cell_field(inverse_diagonal, 1);
      prod_in[4] = disp_a_ff[2] * cell_field(inverse_lower, 2);
      prod_in[5] = disp_a_ff[2] * cell_field(inverse_diagonal, 2);
   end

   always_comb begin
      frac_in[0] = FRAC_BITS'(prod_ff[0]) + FRAC_BITS'(prod_ff[1]) + FRAC_BITS'(prod_ff[2]);
      frac_in[1] = FRAC_BITS'(prod_ff[3]) + FRAC_BITS'(prod_ff[4]);
      frac_in[2] = FRAC_BITS'(prod_ff[5]);
   end

   // Round half away from zero: floor((s + half - (s < 0)) / 2^35), then negate.
   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         rounded[k]  = frac_ff[k] + ROUND_HALF - FRAC_BITS'(frac_ff[k][FRAC_BITS-1]);
         quot_ext[k] = CALC_BITS'($signed(rounded[k][FRAC_BITS-1:FRAC_POINT]));
         neg_quot[k] = -quot_ext[k];
         if (!periodic_mask[k]) begin
            shift_in[k] = '0;
         end else if (neg_quot[k] > SHIFT_MAX) begin
            shift_in[k] = SHIFT_MAX[SHIFT_BITS-1:0];
         end else if (neg_quot[k] < SHIFT_MIN) begin
            shift_in[k] = SHIFT_MIN[SHIFT_BITS-1:0];
         end else begin
            shift_in[k] = neg_quot[k][SHIFT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= in_valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
         if (ready_c) valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         disp_a_ff <= disp_in;
         side_a_ff <= in_side;
      end
      if (ready_b) begin
         disp_b_ff <= disp_a_ff;
         side_b_ff <= side_a_ff;
         prod_ff   <= prod_in;
      end
      if (ready_c) begin
         disp_c_ff <= disp_b_ff;
         side_c_ff <= side_b_ff;
         frac_ff   <= frac_in;
      end
   end

   assign out_valid   = valid_c_ff;
   assign out_disp_x  = disp_c_ff[0];
   assign out_disp_y  = disp_c_ff[1];
   assign out_disp_z  = disp_c_ff[2];
   assign out_side    = side_c_ff;
   assign out_shift_x = shift_in[0];
   assign out_shift_y = shift_in[1];
   assign out_shift_z = shift_in[2];

endmodule

### hw/rtl/min_image_pair_cutoff_filter.sv
// Minimum-image pair cutoff filter, top level; uses mipcf_pkg and mipcf_shift.
// A request beat accepted by the shift unit passes through eight register stages
// before it leaves as a response beat.
// Throughput: one pair per cycle, with one register stage per multiply, wide add
// or compare; a stalled stage holds. Reset is synchronous and active high; it
// empties the pipeline and loads the register defaults (zero, mask all ones).
module min_image_pair_cutoff_filter
   import mipcf_pkg::*;
#(
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_first_x,
   input  logic signed [COORD_BITS-1:0]  req_first_y,
   input  logic signed [COORD_BITS-1:0]  req_first_z,
   input  logic signed [COORD_BITS-1:0]  req_second_x,
   input  logic signed [COORD_BITS-1:0]  req_second_y,
   input  logic signed [COORD_BITS-1:0]  req_second_z,
   input  logic [INDEX_BITS-1:0]         req_first_index,
   input  logic [INDEX_BITS-1:0]         req_second_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_pair_valid,
   output logic [INDEX_BITS-1:0]         rsp_source_index,
   output logic [INDEX_BITS-1:0]         rsp_dest_index,
   output logic signed [SHIFT_BITS-1:0]  rsp_image_shift_x,
   output logic signed [SHIFT_BITS-1:0]  rsp_image_shift_y,
   output logic signed [SHIFT_BITS-1:0]  rsp_image_shift_z
);

   localparam int DISP_BITS = COORD_BITS + 1;
   localparam int SIDE_BITS = 2 * INDEX_BITS;
   localparam int E_BITS = ((DISP_BITS > TERM_BITS + CELL_POINT) ?
                            DISP_BITS : TERM_BITS + CELL_POINT) + 1;

   logic [CSR_DATA_BITS-1:0] cell_diagonal_ff, cell_tilts_ff;
   logic [CSR_DATA_BITS-1:0] inverse_diagonal_ff, inverse_lower_ff;
   logic [MASK_BITS-1:0]     periodic_mask_ff;
   logic [CUTOFF_BITS-1:0]   cutoff_squared_ff;

   logic valid_5_ff, valid_6_ff, valid_7_ff, valid_8_ff, rsp_valid_ff;
   logic ready_5, ready_6, ready_7, ready_8, ready_9;
   logic shift_in_ready, shift_out_valid;

   logic signed [DISP_BITS-1:0]  disp_in    [AXES];

   logic signed [DISP_BITS-1:0]  shift_disp [AXES];
   logic [SIDE_BITS-1:0]         shift_side;
   logic signed [SHIFT_BITS-1:0] shift_out  [AXES];

   logic signed [DISP_BITS-1:0]  disp_5_ff  [AXES];
   logic signed [DISP_BITS-1:0]  disp_6_ff  [AXES];
   logic [SIDE_BITS-1:0]         side_5_ff, side_6_ff, side_7_ff, side_8_ff;
   logic signed [SHIFT_BITS-1:0] shift_5_ff [AXES];
   logic signed [SHIFT_BITS-1:0] shift_6_ff [AXES];
   logic signed [SHIFT_BITS-1:0] shift_7_ff [AXES];
   logic signed [SHIFT_BITS-1:0] shift_8_ff [AXES];
   logic signed [TERM_BITS-1:0]  term_in    [AXES];
   logic signed [TERM_BITS-1:0]  term_6_ff  [AXES];

   logic signed [E_BITS-1:0]     image_in   [AXES];
   logic [E_BITS-1:0]            abs_in     [AXES];
   logic [MAG_BITS-1:0]          mag_7_ff   [AXES];
   logic [AXES-1:0]              over_in, over_7_ff;
   logic                         over_8_ff;
   logic [SQ_BITS-1:0]           sq_8_ff    [AXES];

   logic [SUM_BITS-1:0]          dist_sum, cutoff_limit;
   logic                         pair_ok;

   logic                         rsp_pair_valid_ff;
   logic [INDEX_BITS-1:0]        rsp_source_index_ff, rsp_dest_index_ff;
   logic signed [SHIFT_BITS-1:0] rsp_shift_ff [AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_diagonal_ff    <= '0;
         cell_tilts_ff       <= '0;
         inverse_diagonal_ff <= '0;
         inverse_lower_ff    <= '0;
         periodic_mask_ff    <= MASK_RESET;
         cutoff_squared_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CELL_DIAGONAL:    cell_diagonal_ff    <= csr_write_data;
            CSR_CELL_TILTS:       cell_tilts_ff       <= csr_write_data;
            CSR_INVERSE_DIAGONAL: inverse_diagonal_ff <= csr_write_data;
            CSR_INVERSE_LOWER:    inverse_lower_ff    <= csr_write_data;
            CSR_PERIODIC_MASK:    periodic_mask_ff    <= csr_write_data[MASK_BITS-1:0];
            CSR_CUTOFF_SQUARED:   cutoff_squared_ff   <= csr_write_data[CUTOFF_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign ready_9   = !rsp_valid_ff || !rsp_stall;
   assign ready_8   = !valid_8_ff || ready_9;
   assign ready_7   = !valid_7_ff || ready_8;
   assign ready_6   = !valid_6_ff || ready_7;
   assign ready_5   = !valid_5_ff || ready_6;
   assign req_stall = !shift_in_ready;

   assign disp_in[0] = DISP_BITS'(req_second_x) - DISP_BITS'(req_first_x);
   assign disp_in[1] = DISP_BITS'(req_second_y) - DISP_BITS'(req_first_y);
   assign disp_in[2] = DISP_BITS'(req_second_z) - DISP_BITS'(req_first_z);

   mipcf_shift #(
      .DISP_BITS (DISP_BITS),
      .SIDE_BITS (SIDE_BITS)
   ) u_shift (
      .clock            (clock),
      .reset            (reset),
      .inverse_diagonal (inverse_diagonal_ff),
      .inverse_lower    (inverse_lower_ff),
      .periodic_mask    (periodic_mask_ff),
      .in_valid         (req_valid),
      .in_ready         (shift_in_ready),
      .in_disp_x        (disp_in[0]),
      .in_disp_y        (disp_in[1]),
      .in_disp_z        (disp_in[2]),
      .in_side          ({req_first_index, req_second_index}),
      .out_valid        (shift_out_valid),
      .out_ready        (ready_5),
      .out_disp_x       (shift_disp[0]),
      .out_disp_y       (shift_disp[1]),
      .out_disp_z       (shift_disp[2]),
      .out_side         (shift_side),
      .out_shift_x      (shift_out[0]),
      .out_shift_y      (shift_out[1]),
      .out_shift_z      (shift_out[2])
   );

   always_comb begin
      term_in[0] = shift_5_ff[0] * cell_field(cell_diagonal_ff, 0)
                 + shift_5_ff[1] * cell_field(cell_tilts_ff, 0)
                 + shift_5_ff[2] * cell_field(cell_tilts_ff, 1);
      term_in[1] = shift_5_ff[1] * cell_field(cell_diagonal_ff, 1)
                 + shift_5_ff[2] * cell_field(cell_tilts_ff, 2);
      term_in[2] = shift_5_ff[2] * cell_field(cell_diagonal_ff, 2);
   end

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         image_in[k] = E_BITS'(disp_6_ff[k]) + (E_BITS'(term_6_ff[k]) <<< CELL_POINT);
         abs_in[k]   = image_in[k][E_BITS-1] ? E_BITS'(-image_in[k]) : E_BITS'(image_in[k]);
         over_in[k]  = |abs_in[k][E_BITS-1:MAG_BITS];
      end
   end

   assign dist_sum     = SUM_BITS'(sq_8_ff[0]) + SUM_BITS'(sq_8_ff[1]) + SUM_BITS'(sq_8_ff[2]);
   assign cutoff_limit = SUM_BITS'({cutoff_squared_ff, {CUTOFF_POINT{1'b0}}});
   assign pair_ok      = !over_8_ff && (dist_sum <= cutoff_limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_5_ff   <= 1'b0;
         valid_6_ff   <= 1'b0;
         valid_7_ff   <= 1'b0;
         valid_8_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready_5) valid_5_ff   <= shift_out_valid;
         if (ready_6) valid_6_ff   <= valid_5_ff;
         if (ready_7) valid_7_ff   <= valid_6_ff;
         if (ready_8) valid_8_ff   <= valid_7_ff;
         if (ready_9) rsp_valid_ff <= valid_8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_5) begin
         disp_5_ff  <= shift_disp;
         side_5_ff  <= shift_side;
         shift_5_ff <= shift_out;
      end
      if (ready_6) begin
         term_6_ff  <= term_in;
         disp_6_ff  <= disp_5_ff;
         side_6_ff  <= side_5_ff;
         shift_6_ff <= shift_5_ff;
      end
      if (ready_7) begin
         side_7_ff  <= side_6_ff;
         shift_7_ff <= shift_6_ff;
         over_7_ff  <= over_in;
         for (int k = 0; k < AXES; k++) begin
            mag_7_ff[k] <= abs_in[k][MAG_BITS-1:0];
         end
      end
      if (ready_8) begin
         side_8_ff  <= side_7_ff;
         shift_8_ff <= shift_7_ff;
         over_8_ff  <= |over_7_ff;
         for (int k = 0; k < AXES; k++) begin
            sq_8_ff[k] <= mag_7_ff[k] * mag_7_ff[k];
         end
      end
      if (ready_9) begin
         rsp_pair_valid_ff   <= pair_ok;
         rsp_source_index_ff <= pair_ok ? side_8_ff[SIDE_BITS-1:INDEX_BITS] : '0;
         rsp_dest_index_ff   <= pair_ok ? side_8_ff[INDEX_BITS-1:0] : '0;
         for (int k = 0; k < AXES; k++) begin
            rsp_shift_ff[k] <= pair_ok ? shift_8_ff[k] : '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pair_valid    = rsp_pair_valid_ff;
   assign rsp_source_index  = rsp_source_index_ff;
   assign rsp_dest_index    = rsp_dest_index_ff;
   assign rsp_image_shift_x = rsp_shift_ff[0];
   assign rsp_image_shift_y = rsp_shift_ff[1];
   assign rsp_image_shift_z = rsp_shift_ff[2];

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for min_image_pair_cutoff_filter: directed and random pair beats
// under several cell settings, checked against an in-bench minimum-image predictor.
// Depends on mipcf_pkg and the RTL of the block only.
module tb;
   import mipcf_pkg::*;

   localparam int IDX_W = INDEX_BITS_DEFAULT;
   localparam int POS_W = COORD_BITS_DEFAULT;
   localparam int LATENCY = 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PAIRS = 130;
   localparam int STEP_BITS = FRAC_POINT - 16;
   localparam longint ROUND_HALF = 64'sd1 <<< (STEP_BITS - 1);
   localparam real ANGSTROM = 65536.0;
   localparam real INVERSE_ONE = 524288.0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LOW = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HIGH = 3'd7;

   typedef struct packed {
      logic [AXES-1:0][POS_W-1:0] first_pos;
      logic [AXES-1:0][POS_W-1:0] second_pos;
      logic [IDX_W-1:0]           first_index;
      logic [IDX_W-1:0]           second_index;
   } pair_beat_type;

   typedef struct packed {
      logic                            pair_valid;
      logic [IDX_W-1:0]                source_index;
      logic [IDX_W-1:0]                dest_index;
      logic [AXES-1:0][SHIFT_BITS-1:0] image_shift;
   } image_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [POS_W-1:0] req_first_x = '0;
   logic signed [POS_W-1:0] req_first_y = '0;
   logic signed [POS_W-1:0] req_first_z = '0;
   logic signed [POS_W-1:0] req_second_x = '0;
   logic signed [POS_W-1:0] req_second_y = '0;
   logic signed [POS_W-1:0] req_second_z = '0;
   logic [IDX_W-1:0] req_first_index = '0;
   logic [IDX_W-1:0] req_second_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_pair_valid;
   logic [IDX_W-1:0] rsp_source_index;
   logic [IDX_W-1:0] rsp_dest_index;
   logic signed [SHIFT_BITS-1:0] rsp_image_shift_x;
   logic signed [SHIFT_BITS-1:0] rsp_image_shift_y;
   logic signed [SHIFT_BITS-1:0] rsp_image_shift_z;

   logic [CSR_DATA_BITS-1:0] cell_diag_q;
   logic [CSR_DATA_BITS-1:0] cell_tilt_q;
   logic [CSR_DATA_BITS-1:0] inv_diag_q;
   logic [CSR_DATA_BITS-1:0] inv_lower_q;
   logic [MASK_BITS-1:0] periodic_q;
   logic [CUTOFF_BITS-1:0] cutoff_q;

   pair_beat_type pending_pairs[$];
   image_result_type expected_results[$];
   image_result_type oldest;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int failures = 0;
   int quiet_cycles = 0;

   min_image_pair_cutoff_filter DUT (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_first_x(req_first_x),
      .req_first_y(req_first_y),
      .req_first_z(req_first_z),
      .req_second_x(req_second_x),
      .req_second_y(req_second_y),
      .req_second_z(req_second_z),
      .req_first_index(req_first_index),
      .req_second_index(req_second_index),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pair_valid(rsp_pair_valid),
      .rsp_source_index(rsp_source_index),
      .rsp_dest_index(rsp_dest_index),
      .rsp_image_shift_x(rsp_image_shift_x),
      .rsp_image_shift_y(rsp_image_shift_y),
      .rsp_image_shift_z(rsp_image_shift_z)
   );

   always #6 clock = ~clock;

   function automatic longint field_value(logic [CSR_DATA_BITS-1:0] packed_regs, int slot);
      logic signed [FIELD_BITS-1:0] raw;
      raw = packed_regs[slot*FIELD_BITS +: FIELD_BITS];
      return longint'(raw);
   endfunction

   function automatic void accumulate(input longint disp, input longint inv,
                                      inout longint coarse, inout longint fine);
      longint upper, lower;
      upper = disp >>> 16;
      lower = disp - (upper <<< 16);
      coarse += upper * inv;
      fine += lower * inv;
   endfunction

   function automatic longint nearest_shift(longint coarse, longint fine);
      longint carry, total, rem, mag, adj, n;
      carry = fine >>> 16;
      total = coarse + carry;
      rem = fine - (carry <<< 16);
      if (total >= 0) begin
         n = (total + ROUND_HALF) >>> STEP_BITS;
      end else begin
         mag = -total;
         adj = (rem != 0) ? 1 : 0;
         n = -((mag + ROUND_HALF - adj) >>> STEP_BITS);
      end
      n = -n;
      if (n > 127) n = 127;
      if (n < -128) n = -128;
      return n;
   endfunction

   function automatic longint unsigned square_clip(longint v);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      if (mag >= (64'd1 << MAG_BITS)) return '1;
      return mag * mag;
   endfunction

   function automatic longint unsigned add_clip(longint unsigned a, longint unsigned b);
      return (a > ~b) ? '1 : a + b;
   endfunction

   function automatic image_result_type predict_image_pair(pair_beat_type p);
      image_result_type r;
      longint disp[AXES], coarse[AXES], fine[AXES], shift[AXES], img[AXES];
      longint box[AXES], tilt[AXES], inv_d[AXES], inv_l[AXES];
      longint unsigned dist_sq, limit;
      int a;
      for (a = 0; a < AXES; a++) begin
         disp[a] = longint'($signed(p.second_pos[a])) - longint'($signed(p.first_pos[a]));
         box[a] = field_value(cell_diag_q, a);
         tilt[a] = field_value(cell_tilt_q, a);
         inv_d[a] = field_value(inv_diag_q, a);
         inv_l[a] = field_value(inv_lower_q, a);
         coarse[a] = 0;
         fine[a] = 0;
         shift[a] = 0;
      end
      // The inverse cell is upper triangular, entries (0,1), (0,2), (1,2) in inv_l.
      accumulate(disp[0], inv_d[0], coarse[0], fine[0]);
      accumulate(disp[1], inv_l[0], coarse[0], fine[0]);
      accumulate(disp[2], inv_l[1], coarse[0], fine[0]);
      accumulate(disp[1], inv_d[1], coarse[1], fine[1]);
      accumulate(disp[2], inv_l[2], coarse[1], fine[1]);
      accumulate(disp[2], inv_d[2], coarse[2], fine[2]);
      for (a = 0; a < AXES; a++) begin
         if (periodic_q[a]) shift[a] = nearest_shift(coarse[a], fine[a]);
      end
      // Cell entries are Q.8 and positions Q.16, hence the factor of 256.
      img[0] = disp[0] + (shift[0] * box[0] + shift[1] * tilt[0] + shift[2] * tilt[1]) * 256;
      img[1] = disp[1] + (shift[1] * box[1] + shift[2] * tilt[2]) * 256;
      img[2] = disp[2] + shift[2] * box[2] * 256;
      dist_sq = add_clip(add_clip(square_clip(img[0]), square_clip(img[1])),
                         square_clip(img[2]));
      limit = 64'(cutoff_q);
      limit = limit << CUTOFF_POINT;
      r = '0;
      if (dist_sq <= limit) begin
         r.pair_valid = 1'b1;
         r.source_index = p.first_index;
         r.dest_index = p.second_index;
         for (a = 0; a < AXES; a++) r.image_shift[a] = shift[a][SHIFT_BITS-1:0];
      end
      return r;
   endfunction

   task automatic drive_pair(pair_beat_type p);
      req_first_x <= p.first_pos[0];
      req_first_y <= p.first_pos[1];
      req_first_z <= p.first_pos[2];
      req_second_x <= p.second_pos[0];
      req_second_y <= p.second_pos[1];
      req_second_z <= p.second_pos[2];
      req_first_index <= p.first_index;
      req_second_index <= p.second_index;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_image_pair(pending_pairs.pop_front()));
         end
         if (!req_valid || !req_stall) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               drive_pair(pending_pairs[0]);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("response beat arrived with no pair outstanding");
               failures++;
            end else begin
               oldest = expected_results.pop_front();
               compare_field("pair_valid", oldest.pair_valid, rsp_pair_valid);
               compare_field("source_index", oldest.source_index, rsp_source_index);
               compare_field("dest_index", oldest.dest_index, rsp_dest_index);
               compare_field("image_shift_x", $signed(oldest.image_shift[0]), rsp_image_shift_x);
               compare_field("image_shift_y", $signed(oldest.image_shift[1]), rsp_image_shift_y);
               compare_field("image_shift_z", $signed(oldest.image_shift[2]), rsp_image_shift_z);
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_CELL_DIAGONAL: cell_diag_q = value;
         CSR_CELL_TILTS: cell_tilt_q = value;
         CSR_INVERSE_DIAGONAL: inv_diag_q = value;
         CSR_INVERSE_LOWER: inv_lower_q = value;
         CSR_PERIODIC_MASK: periodic_q = value[MASK_BITS-1:0];
         CSR_CUTOFF_SQUARED: cutoff_q = value[CUTOFF_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain();
      while (pending_pairs.size() != 0 || expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pack_fields(longint a, longint b, longint c);
      return {c[FIELD_BITS-1:0], b[FIELD_BITS-1:0], a[FIELD_BITS-1:0]};
   endfunction

   function automatic logic [CUTOFF_BITS-1:0] cutoff_code(real reach);
      return CUTOFF_BITS'(longint'(reach * reach * ANGSTROM));
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] rand_word();
      return CSR_DATA_BITS'({$urandom, $urandom});
   endfunction

   // Quantizes the cell to Q.8 and derives the Q.19 inverse from the quantized values.
   task automatic load_cell(input real lx, input real ly, input real lz, input real txy,
                            input real txz, input real tyz,
                            input logic [MASK_BITS-1:0] mask,
                            input logic [CUTOFF_BITS-1:0] cutoff);
      longint qlx, qly, qlz, qxy, qxz, qyz;
      real ax, ay, az, bxy, bxz, byz;
      qlx = longint'(lx * 256.0);
      qly = longint'(ly * 256.0);
      qlz = longint'(lz * 256.0);
      qxy = longint'(txy * 256.0);
      qxz = longint'(txz * 256.0);
      qyz = longint'(tyz * 256.0);
      ax = qlx / 256.0;
      ay = qly / 256.0;
      az = qlz / 256.0;
      bxy = qxy / 256.0;
      bxz = qxz / 256.0;
      byz = qyz / 256.0;
      write_register(CSR_CELL_DIAGONAL, pack_fields(qlx, qly, qlz));
      write_register(CSR_CELL_TILTS, pack_fields(qxy, qxz, qyz));
      write_register(CSR_INVERSE_DIAGONAL,
                     pack_fields(longint'(INVERSE_ONE / ax), longint'(INVERSE_ONE / ay),
                                 longint'(INVERSE_ONE / az)));
      write_register(CSR_INVERSE_LOWER,
                     pack_fields(longint'(-bxy / (ax * ay) * INVERSE_ONE),
                                 longint'((bxy * byz - bxz * ay) / (ax * ay * az) * INVERSE_ONE),
                                 longint'(-byz / (ay * az) * INVERSE_ONE)));
      write_register(CSR_PERIODIC_MASK, CSR_DATA_BITS'(mask));
      write_register(CSR_CUTOFF_SQUARED, CSR_DATA_BITS'(cutoff));
   endtask

   task automatic load_random_cell(input bit tilted, input logic [MASK_BITS-1:0] mask,
                                   input bit wide_cutoff);
      real lx, ly, lz, txy, txz, tyz, shortest;
      logic [CUTOFF_BITS-1:0] cut;
      lx = real'($urandom_range(512, 10240)) / 256.0;
      ly = real'($urandom_range(512, 10240)) / 256.0;
      lz = real'($urandom_range(512, 10240)) / 256.0;
      txy = 0.0;
      txz = 0.0;
      tyz = 0.0;
      if (tilted) begin
         txy = (real'($urandom_range(0, 1000)) / 1000.0 - 0.5) * lx;
         txz = (real'($urandom_range(0, 1000)) / 1000.0 - 0.5) * lx;
         tyz = (real'($urandom_range(0, 1000)) / 1000.0 - 0.5) * ly;
      end
      shortest = (lx < ly) ? lx : ly;
      shortest = (lz < shortest) ? lz : shortest;
      if (wide_cutoff) begin
         cut = CUTOFF_BITS'(rand_word());
      end else begin
         cut = cutoff_code(shortest * (0.3 + real'($urandom_range(0, 400)) / 1000.0));
      end
      load_cell(lx, ly, lz, txy, txz, tyz, mask, cut);
   endtask

   function automatic pair_beat_type pair_from(real ox, real oy, real oz);
      pair_beat_type p;
      longint offset[AXES];
      longint center;
      int a;
      offset[0] = longint'(ox * ANGSTROM);
      offset[1] = longint'(oy * ANGSTROM);
      offset[2] = longint'(oz * ANGSTROM);
      for (a = 0; a < AXES; a++) begin
         center = longint'($signed($urandom)) >>> 9;
         p.first_pos[a] = POS_W'(center);
         p.second_pos[a] = POS_W'(center + offset[a]);
      end
      p.first_index = IDX_W'($urandom);
      p.second_index = IDX_W'($urandom);
      return p;
   endfunction

   function automatic pair_beat_type extreme_pair(bit flip);
      pair_beat_type p;
      p.first_pos = flip ? {AXES{32'h7FFF_FFFF}} : {AXES{32'h8000_0000}};
      p.second_pos = flip ? {AXES{32'h8000_0000}} : {AXES{32'h7FFF_FFFF}};
      p.first_index = IDX_W'($urandom);
      p.second_index = IDX_W'($urandom);
      return p;
   endfunction

   // Mostly pairs offset by up to 2, 20, 80 or 3000 Angstrom around a random center; the rest is full-range noise.
   function automatic pair_beat_type random_pair();
      pair_beat_type p;
      longint center, reach;
      int unsigned pick;
      int a;
      pick = $urandom_range(0, 99);
      p.first_index = IDX_W'($urandom);
      p.second_index = IDX_W'($urandom);
      case (pick % 4)
         0: reach = 2 * 65536;
         1: reach = 20 * 65536;
         2: reach = 80 * 65536;
         default: reach = 3000 * 65536;
      endcase
      for (a = 0; a < AXES; a++) begin
         if (pick < 25) begin
            p.first_pos[a] = $urandom;
            p.second_pos[a] = $urandom;
         end else begin
            center = longint'($signed($urandom)) >>> $urandom_range(0, 10);
            p.first_pos[a] = POS_W'(center);
            p.second_pos[a] = POS_W'(center + longint'($urandom_range(0, 32'(2 * reach)))
                                      - reach);
         end
      end
      return p;
   endfunction

   initial begin
      pair_beat_type p;
      int phase;
      cell_diag_q = '0;
      cell_tilt_q = '0;
      inv_diag_q = '0;
      inv_lower_q = '0;
      periodic_q = MASK_RESET;
      cutoff_q = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: zero cell and inverse, zero cutoff, every axis periodic.
      @(negedge clock);
      pending_pairs.push_back(pair_from(0.0, 0.0, 0.0));
      pending_pairs.push_back(pair_from(1.0 / ANGSTROM, 0.0, 0.0));
      pending_pairs.push_back(extreme_pair(1'b0));
      drain();

      load_cell(10.0, 12.0, 15.0, 0.0, 0.0, 0.0, '1, cutoff_code(6.0));
      write_register(CSR_UNMAPPED_LOW, rand_word());
      write_register(CSR_UNMAPPED_HIGH, rand_word());
      @(negedge clock);
      p = pair_from(5.0, 0.0, 0.0);
      p.first_index = '1;
      p.second_index = '0;
      pending_pairs.push_back(p);
      p = pair_from(-5.0, 0.0, 0.0);
      p.first_index = '0;
      p.second_index = '1;
      pending_pairs.push_back(p);
      pending_pairs.push_back(pair_from(25.0, 0.0, 0.0));
      pending_pairs.push_back(pair_from(4.0, 4.0, 4.0));
      pending_pairs.push_back(pair_from(0.0, 0.0, 6.0));
      pending_pairs.push_back(pair_from(0.0, 0.0, 6.0 + 1.0 / ANGSTROM));
      pending_pairs.push_back(pair_from(-2000.0, 0.0, 0.0));
      pending_pairs.push_back(extreme_pair(1'b1));
      drain();

      // Saturated shifts that still land inside a very large cutoff.
      write_register(CSR_CUTOFF_SQUARED, '1);
      @(negedge clock);
      pending_pairs.push_back(pair_from(2000.0, 0.0, 0.0));
      pending_pairs.push_back(pair_from(-2000.0, 0.0, 0.0));
      drain();

      write_register(CSR_PERIODIC_MASK, '0);
      write_register(CSR_CUTOFF_SQUARED, CSR_DATA_BITS'(cutoff_code(6.0)));
      @(negedge clock);
      pending_pairs.push_back(pair_from(9.0, 0.0, 0.0));
      pending_pairs.push_back(pair_from(3.0, 0.0, 0.0));
      drain();
      write_register(CSR_PERIODIC_MASK, CSR_DATA_BITS'(3'b101));
      @(negedge clock);
      pending_pairs.push_back(pair_from(0.0, 7.0, 0.0));
      drain();

      load_cell(8.0, 9.0, 11.0, 2.5, -3.0, 1.75, '1, cutoff_code(5.0));
      @(negedge clock);
      pending_pairs.push_back(pair_from(4.0, 4.5, 5.5));
      pending_pairs.push_back(pair_from(-7.0, 2.0, 10.0));
      pending_pairs.push_back(pair_from(1.0, -1.0, 0.5));
      drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 6)
            0: load_random_cell(1'b0, '1, 1'b0);
            1: load_random_cell(1'b1, '1, 1'b0);
            2: load_random_cell(1'b1, MASK_BITS'($urandom), 1'b0);
            3: load_random_cell(1'b1, MASK_BITS'($urandom), 1'b1);
            4: begin
               write_register(CSR_CELL_DIAGONAL, rand_word());
               write_register(CSR_CELL_TILTS, rand_word());
               write_register(CSR_INVERSE_DIAGONAL, rand_word());
               write_register(CSR_INVERSE_LOWER, rand_word());
               write_register(CSR_PERIODIC_MASK, rand_word());
               write_register(CSR_CUTOFF_SQUARED, rand_word());
            end
            default: begin
               if (phase < 6) begin
                  write_register(CSR_CELL_DIAGONAL, '1);
                  write_register(CSR_CELL_TILTS, '1);
                  write_register(CSR_INVERSE_DIAGONAL, '1);
                  write_register(CSR_INVERSE_LOWER, '1);
                  write_register(CSR_PERIODIC_MASK, '1);
                  write_register(CSR_CUTOFF_SQUARED, '1);
               end else begin
                  write_register(CSR_CELL_DIAGONAL, {AXES{21'h10_0000}});
                  write_register(CSR_CELL_TILTS, {AXES{21'h10_0000}});
                  write_register(CSR_INVERSE_DIAGONAL, {AXES{21'h10_0000}});
                  write_register(CSR_INVERSE_LOWER, {AXES{21'h10_0000}});
                  write_register(CSR_PERIODIC_MASK, '1);
                  write_register(CSR_CUTOFF_SQUARED, '0);
               end
            end
         endcase
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 56;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 56;
            end
            default: begin
               send_idle_pct = 29;
               rsp_stall_pct = 29;
            end
         endcase
         @(negedge clock);
         repeat (PHASE_PAIRS) pending_pairs.push_back(random_pair());
         drain();
      end

      repeat (LATENCY * 4) @(posedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
